FILE: rtl/ggx_pkg.sv
// ----------------------------------------------------------------------------
// ggx_pkg
// Word types, fixed-point widths and helper functions for the GGX reflectance
// pipeline.
// ----------------------------------------------------------------------------
package ggx_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int COMP_W      = 16;
    localparam int ROUGH_W     = 15;
    localparam int REFL_W      = 32;
    localparam int ROUGH_RESET = 8192;

    localparam int PROD_W = 2 * COMP_W;
    localparam int DOT_W  = 2 * COMP_W + 2;
    localparam int C_W    = FRAC_BITS + 1;
    localparam int C2_W   = 2 * FRAC_BITS + 1;
    localparam int A2_W   = 2 * ROUGH_W + 1 - FRAC_BITS;
    localparam int T_W    = A2_W + C2_W;
    localparam int Y_W    = ((T_W - FRAC_BITS + 1 > C2_W) ? T_W - FRAC_BITS + 1 : C2_W) + 1;
    localparam int SQ_N   = (Y_W + 1) / 2;
    localparam int SQ_W   = SQ_N + 1;
    localparam int Q_W    = Y_W - FRAC_BITS + 1;
    localparam int F_W    = ((SQ_W > C_W) ? SQ_W : C_W) + 1;
    localparam int QQ_W   = 2 * Q_W;
    localparam int FF_W   = 2 * F_W;
    localparam int PI_W   = 18;
    localparam int PQ_W   = PI_W + QQ_W;
    localparam int PQ_LO_W = (PQ_W + 1) / 2;
    localparam int PQ_HI_W = PQ_W - PQ_LO_W;
    localparam int FF_LO_W = (FF_W + 1) / 2;
    localparam int FF_HI_W = FF_W - FF_LO_W;
    localparam int DEN_W  = PQ_W + FF_W;
    localparam int NUM_W  = A2_W + 3 * FRAC_BITS;
    localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = REFL_W;

    localparam logic [PI_W-1:0] PI_Q16 = PI_W'(205887);
    localparam int              HALF   = 1 << (FRAC_BITS - 1);
    localparam logic [C2_W-1:0] ONE2   = C2_W'(1) << (2 * FRAC_BITS);
    localparam logic [C_W-1:0]  ONE    = C_W'(1) << FRAC_BITS;
    localparam int A2_RESET = (ROUGH_RESET * ROUGH_RESET + HALF) >> FRAC_BITS;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_dir_x;
        logic signed [COMP_W-1:0] in_dir_y;
        logic signed [COMP_W-1:0] in_dir_z;
        logic signed [COMP_W-1:0] out_dir_x;
        logic signed [COMP_W-1:0] out_dir_y;
        logic signed [COMP_W-1:0] out_dir_z;
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic signed [COMP_W-1:0] micro_x;
        logic signed [COMP_W-1:0] micro_y;
        logic signed [COMP_W-1:0] micro_z;
    } in_word_t;

    typedef struct packed {
        logic [REFL_W-1:0] reflectance;
        logic              saturated;
    } out_word_t;

    // magnitude rounded half up to FRAC_BITS, clamped to one
    function automatic logic [C_W-1:0] cos_mag(input logic signed [DOT_W-1:0] d);
        logic [DOT_W-1:0] mag;
        logic [DOT_W:0]   rnd;
        logic [DOT_W:0]   sh;
        mag = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
        rnd = {1'b0, mag} + (DOT_W+1)'(HALF);
        sh  = rnd >> FRAC_BITS;
        return (sh > (DOT_W+1)'(ONE)) ? ONE : C_W'(sh);
    endfunction

    function automatic logic g_pass(input logic signed [DOT_W-1:0] vn,
                                    input logic signed [DOT_W-1:0] vm);
        return (vn != '0) && (vm != '0) && (vn[DOT_W-1] == vm[DOT_W-1]);
    endfunction

endpackage

FILE: rtl/ggx_isqrt.sv
// ----------------------------------------------------------------------------
// ggx_isqrt
// Two-lane pipelined integer square root, one result bit per stage, rounded
// to nearest at the output. A tag travels alongside.
// ----------------------------------------------------------------------------
module ggx_isqrt import ggx_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [Y_W-1:0]   in_y_a,
    input  logic [Y_W-1:0]   in_y_b,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [SQ_W-1:0]  out_s_a,
    output logic [SQ_W-1:0]  out_s_b,
    output logic [TAG_W-1:0] out_tag
);

    localparam int RW = Y_W + 1;

    logic             valid_reg  [SQ_N];
    logic             valid_next [SQ_N];
    logic [Y_W-1:0]   y_reg      [SQ_N][2];
    logic [Y_W-1:0]   y_next     [SQ_N][2];
    logic [RW-1:0]    r_reg      [SQ_N][2];
    logic [RW-1:0]    r_next     [SQ_N][2];
    logic [TAG_W-1:0] tag_reg    [SQ_N];
    logic [TAG_W-1:0] tag_next   [SQ_N];

    always_comb begin
        logic [Y_W-1:0] y_p;
        logic [RW-1:0]  r_p;
        logic [RW-1:0]  bitv;
        logic [RW-1:0]  sum;
        for (int s = 0; s < SQ_N; s++) begin
            if (s == 0) begin
                valid_next[s] = in_valid;
                tag_next[s]   = in_tag;
            end else begin
                valid_next[s] = valid_reg[s-1];
                tag_next[s]   = tag_reg[s-1];
            end
            bitv = RW'(1) << (2 * (SQ_N - 1 - s));
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    y_p = (l == 0) ? in_y_a : in_y_b;
                    r_p = '0;
                end else begin
                    y_p = y_reg[s-1][l];
                    r_p = r_reg[s-1][l];
                end
                sum = r_p + bitv;
                if ({1'b0, y_p} >= sum) begin
                    y_next[s][l] = y_p - sum[Y_W-1:0];
                    r_next[s][l] = (r_p >> 1) + bitv;
                end else begin
                    y_next[s][l] = y_p;
                    r_next[s][l] = r_p >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '{default: 1'b0};
        end else if (en) begin
            valid_reg <= valid_next;
        end
        if (en) begin
            y_reg   <= y_next;
            r_reg   <= r_next;
            tag_reg <= tag_next;
        end
    end

    always_comb begin
        logic [RW-1:0] ra;
        logic [RW-1:0] rb;
        ra = r_reg[SQ_N-1][0];
        rb = r_reg[SQ_N-1][1];
        out_s_a = ({1'b0, y_reg[SQ_N-1][0]} > ra) ? SQ_W'(ra + RW'(1)) : SQ_W'(ra);
        out_s_b = ({1'b0, y_reg[SQ_N-1][1]} > rb) ? SQ_W'(rb + RW'(1)) : SQ_W'(rb);
    end

    assign out_valid = valid_reg[SQ_N-1];
    assign out_tag   = tag_reg[SQ_N-1];

endmodule

FILE: rtl/ggx_div.sv
// ----------------------------------------------------------------------------
// ggx_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The partial remainder enters pre-aligned and stays below twice the divisor.
// ----------------------------------------------------------------------------
module ggx_div import ggx_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [REM_W-1:0] in_rem,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);

    logic             valid_reg  [QUO_W];
    logic             valid_next [QUO_W];
    logic [REM_W-1:0] rem_reg    [QUO_W];
    logic [REM_W-1:0] rem_next   [QUO_W];
    logic [DEN_W-1:0] den_reg    [QUO_W];
    logic [DEN_W-1:0] den_next   [QUO_W];
    logic [QUO_W-1:0] quo_reg    [QUO_W];
    logic [QUO_W-1:0] quo_next   [QUO_W];
    logic [TAG_W-1:0] tag_reg    [QUO_W];
    logic [TAG_W-1:0] tag_next   [QUO_W];

    always_comb begin
        logic [REM_W-1:0] p;
        logic [QUO_W-1:0] qp;
        logic [REM_W-1:0] dx;
        logic             ge;
        for (int s = 0; s < QUO_W; s++) begin
            if (s == 0) begin
                valid_next[s] = in_valid;
                p             = in_rem;
                den_next[s]   = in_den;
                qp            = '0;
                tag_next[s]   = in_tag;
            end else begin
                valid_next[s] = valid_reg[s-1];
                p             = rem_reg[s-1];
                den_next[s]   = den_reg[s-1];
                qp            = quo_reg[s-1];
                tag_next[s]   = tag_reg[s-1];
            end
            dx = {1'b0, den_next[s]};
            ge = (p >= dx);
            rem_next[s] = (ge ? (p - dx) : p) << 1;
            quo_next[s] = {qp[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '{default: 1'b0};
        end else if (en) begin
            valid_reg <= valid_next;
        end
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_next;
            quo_reg <= quo_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

FILE: rtl/ggx_microfacet_brdf.sv
// ----------------------------------------------------------------------------
// ggx_microfacet_brdf
// GGX / Smith G1 microfacet reflectance, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one shading sample per cycle while results are taken and returns one
// result word per sample, in order. Its steps: dot products and cosine
// algebra, a bit-per-stage square root, the denominator multiplies, then a
// bit-per-stage 32-bit divider. The whole pipeline advances together; it
// holds when a result is not taken. The user must write roughness through the
// cfg port only while no sample is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module ggx_microfacet_brdf import ggx_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ROUGH_W-1:0] cfg_roughness
);

    localparam int SQ_TAG_W = 1 + 2 * C_W + Q_W;

    logic en;

    logic [A2_W-1:0] a2_reg;
    logic [A2_W-1:0] a2_next;

    // stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] pin_reg [3];
    logic signed [PROD_W-1:0] pim_reg [3];
    logic signed [PROD_W-1:0] pon_reg [3];
    logic signed [PROD_W-1:0] pom_reg [3];
    logic signed [PROD_W-1:0] pmn_reg [3];
    logic signed [COMP_W-1:0] vi [3];
    logic signed [COMP_W-1:0] vo [3];
    logic signed [COMP_W-1:0] vn [3];
    logic signed [COMP_W-1:0] vm [3];

    // stage 2: dot products
    logic                    v2_reg;
    logic signed [DOT_W-1:0] d_in_reg, d_im_reg, d_on_reg, d_om_reg, d_mn_reg;

    // stage 3: cosines
    logic           v3_reg, rej3_reg;
    logic [C_W-1:0] ci3_reg, co3_reg, k3_reg;

    // stage 4: squares
    logic            v4_reg, rej4_reg;
    logic [C_W-1:0]  ci4_reg, co4_reg;
    logic [C2_W-1:0] ci2_4_reg, co2_4_reg, k2_4_reg;

    // stage 5: roughness products
    logic            v5_reg, rej5_reg;
    logic [C_W-1:0]  ci5_reg, co5_reg;
    logic [C2_W-1:0] ci2_5_reg, co2_5_reg, k2_5_reg;
    logic [T_W-1:0]  ti5_reg, to5_reg, tk5_reg;

    // stage 6: square root operands and Q
    logic           v6_reg, rej6_reg;
    logic [C_W-1:0] ci6_reg, co6_reg;
    logic [Y_W-1:0] yi6_reg, yo6_reg;
    logic [Q_W-1:0] q6_reg;
    logic [Y_W-1:0] yi_next, yo_next, q2_next;
    logic [Q_W-1:0] q_next;

    // square root
    logic                sq_valid;
    logic [SQ_W-1:0]     sq_i, sq_o;
    logic [SQ_TAG_W-1:0] sq_tag;
    logic                sq_rej;
    logic [C_W-1:0]      sq_ci, sq_co;
    logic [Q_W-1:0]      sq_q;

    // stage 7 onwards
    logic           v7_reg, rej7_reg;
    logic [Q_W-1:0] q7_reg;
    logic [F_W-1:0] f1_7_reg, f2_7_reg;
    logic [F_W-1:0] f1_next, f2_next;

    logic            v8_reg, rej8_reg;
    logic [QQ_W-1:0] qq8_reg;
    logic [FF_W-1:0] ff8_reg;

    logic            v9_reg, rej9_reg;
    logic [PQ_W-1:0] pq9_reg;
    logic [FF_W-1:0] ff9_reg;

    logic                        v10_reg, rej10_reg;
    logic [PQ_LO_W+FF_LO_W-1:0]  ll10_reg;
    logic [PQ_LO_W+FF_HI_W-1:0]  lh10_reg;
    logic [PQ_HI_W+FF_LO_W-1:0]  hl10_reg;
    logic [PQ_HI_W+FF_HI_W-1:0]  hh10_reg;

    logic                     v11_reg, rej11_reg;
    logic [PQ_LO_W+FF_W-1:0]  la11_reg;
    logic [PQ_HI_W+FF_W-1:0]  hb11_reg;

    logic             v12_reg, rej12_reg;
    logic [DEN_W-1:0] den12_reg;

    logic             v13_reg, rej13_reg, sat13_reg;
    logic [DEN_W-1:0] den13_reg;
    logic [REM_W-1:0] rem13_reg;

    logic             dv_valid;
    logic [QUO_W-1:0] dv_quo;
    logic [1:0]       dv_tag;

    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t m_data_next;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign a2_next = A2_W'(({1'b0, (2*ROUGH_W)'(cfg_roughness) * (2*ROUGH_W)'(cfg_roughness)}
                            + (2*ROUGH_W+1)'(HALF)) >> FRAC_BITS);

    assign vi = '{s_data.in_dir_x,  s_data.in_dir_y,  s_data.in_dir_z};
    assign vo = '{s_data.out_dir_x, s_data.out_dir_y, s_data.out_dir_z};
    assign vn = '{s_data.normal_x,  s_data.normal_y,  s_data.normal_z};
    assign vm = '{s_data.micro_x,   s_data.micro_y,   s_data.micro_z};

    always_comb begin
        logic [T_W:0] ti_r, to_r, tk_r;
        ti_r    = {1'b0, ti5_reg} + (T_W+1)'(HALF);
        to_r    = {1'b0, to5_reg} + (T_W+1)'(HALF);
        tk_r    = {1'b0, tk5_reg} + (T_W+1)'(HALF);
        yi_next = Y_W'(ci2_5_reg) + Y_W'(ti_r >> FRAC_BITS);
        yo_next = Y_W'(co2_5_reg) + Y_W'(to_r >> FRAC_BITS);
        q2_next = Y_W'(ONE2 - k2_5_reg) + Y_W'(tk_r >> FRAC_BITS);
        q_next  = Q_W'(({1'b0, q2_next} + (Y_W+1)'(HALF)) >> FRAC_BITS);
    end

    assign {sq_rej, sq_ci, sq_co, sq_q} = sq_tag;
    assign f1_next = F_W'(sq_ci) + F_W'(sq_i);
    assign f2_next = F_W'(sq_co) + F_W'(sq_o);

    always_comb begin
        m_data_next = '0;
        if (dv_tag[1]) begin
            m_data_next = '0;
        end else if (dv_tag[0]) begin
            m_data_next.reflectance = '1;
            m_data_next.saturated   = 1'b1;
        end else begin
            m_data_next.reflectance = dv_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a2_reg      <= A2_W'(A2_RESET);
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            v10_reg     <= 1'b0;
            v11_reg     <= 1'b0;
            v12_reg     <= 1'b0;
            v13_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                a2_reg <= a2_next;
            end
            if (en) begin
                v1_reg      <= s_valid;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                v5_reg      <= v4_reg;
                v6_reg      <= v5_reg;
                v7_reg      <= sq_valid;
                v8_reg      <= v7_reg;
                v9_reg      <= v8_reg;
                v10_reg     <= v9_reg;
                v11_reg     <= v10_reg;
                v12_reg     <= v11_reg;
                v13_reg     <= v12_reg;
                m_valid_reg <= dv_valid;
            end
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                pin_reg[j] <= vi[j] * vn[j];
                pim_reg[j] <= vi[j] * vm[j];
                pon_reg[j] <= vo[j] * vn[j];
                pom_reg[j] <= vo[j] * vm[j];
                pmn_reg[j] <= vm[j] * vn[j];
            end

            d_in_reg <= DOT_W'(pin_reg[0]) + DOT_W'(pin_reg[1]) + DOT_W'(pin_reg[2]);
            d_im_reg <= DOT_W'(pim_reg[0]) + DOT_W'(pim_reg[1]) + DOT_W'(pim_reg[2]);
            d_on_reg <= DOT_W'(pon_reg[0]) + DOT_W'(pon_reg[1]) + DOT_W'(pon_reg[2]);
            d_om_reg <= DOT_W'(pom_reg[0]) + DOT_W'(pom_reg[1]) + DOT_W'(pom_reg[2]);
            d_mn_reg <= DOT_W'(pmn_reg[0]) + DOT_W'(pmn_reg[1]) + DOT_W'(pmn_reg[2]);

            rej3_reg <= !g_pass(d_in_reg, d_im_reg) || !g_pass(d_on_reg, d_om_reg)
                        || d_mn_reg[DOT_W-1] || (d_mn_reg == '0);
            ci3_reg  <= cos_mag(d_in_reg);
            co3_reg  <= cos_mag(d_on_reg);
            k3_reg   <= cos_mag(d_mn_reg);

            rej4_reg  <= rej3_reg;
            ci4_reg   <= ci3_reg;
            co4_reg   <= co3_reg;
            ci2_4_reg <= ci3_reg * ci3_reg;
            co2_4_reg <= co3_reg * co3_reg;
            k2_4_reg  <= k3_reg * k3_reg;

            rej5_reg  <= rej4_reg;
            ci5_reg   <= ci4_reg;
            co5_reg   <= co4_reg;
            ci2_5_reg <= ci2_4_reg;
            co2_5_reg <= co2_4_reg;
            k2_5_reg  <= k2_4_reg;
            ti5_reg   <= a2_reg * (ONE2 - ci2_4_reg);
            to5_reg   <= a2_reg * (ONE2 - co2_4_reg);
            tk5_reg   <= a2_reg * k2_4_reg;

            rej6_reg <= rej5_reg;
            ci6_reg  <= ci5_reg;
            co6_reg  <= co5_reg;
            yi6_reg  <= yi_next;
            yo6_reg  <= yo_next;
            q6_reg   <= q_next;

            rej7_reg <= sq_rej || (sq_q == '0) || (f1_next == '0) || (f2_next == '0);
            q7_reg   <= sq_q;
            f1_7_reg <= f1_next;
            f2_7_reg <= f2_next;

            rej8_reg <= rej7_reg;
            qq8_reg  <= q7_reg * q7_reg;
            ff8_reg  <= f1_7_reg * f2_7_reg;

            rej9_reg <= rej8_reg;
            pq9_reg  <= PI_Q16 * qq8_reg;
            ff9_reg  <= ff8_reg;

            rej10_reg <= rej9_reg;
            ll10_reg  <= pq9_reg[PQ_LO_W-1:0]    * ff9_reg[FF_LO_W-1:0];
            lh10_reg  <= pq9_reg[PQ_LO_W-1:0]    * ff9_reg[FF_W-1:FF_LO_W];
            hl10_reg  <= pq9_reg[PQ_W-1:PQ_LO_W] * ff9_reg[FF_LO_W-1:0];
            hh10_reg  <= pq9_reg[PQ_W-1:PQ_LO_W] * ff9_reg[FF_W-1:FF_LO_W];

            rej11_reg <= rej10_reg;
            la11_reg  <= (PQ_LO_W+FF_W)'(ll10_reg) + ((PQ_LO_W+FF_W)'(lh10_reg) << FF_LO_W);
            hb11_reg  <= (PQ_HI_W+FF_W)'(hl10_reg) + ((PQ_HI_W+FF_W)'(hh10_reg) << FF_LO_W);

            rej12_reg <= rej11_reg;
            den12_reg <= DEN_W'(la11_reg) + (DEN_W'(hb11_reg) << PQ_LO_W);

            rej13_reg <= rej12_reg;
            sat13_reg <= (CMP_W'({a2_reg, (3*FRAC_BITS)'(0)}) >= CMP_W'(den12_reg));
            den13_reg <= den12_reg;
            rem13_reg <= REM_W'({a2_reg, (3*FRAC_BITS+1)'(0)});

            m_data_reg <= m_data_next;
        end
    end

    ggx_isqrt #(
        .TAG_W (SQ_TAG_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_y_a    (yi6_reg),
        .in_y_b    (yo6_reg),
        .in_tag    ({rej6_reg, ci6_reg, co6_reg, q6_reg}),
        .out_valid (sq_valid),
        .out_s_a   (sq_i),
        .out_s_b   (sq_o),
        .out_tag   (sq_tag)
    );

    ggx_div #(
        .TAG_W (2)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v13_reg),
        .in_rem    (rem13_reg),
        .in_den    (den13_reg),
        .in_tag    ({rej13_reg, sat13_reg}),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

endmodule
